// ----- rtl/gmg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_pkg
// Shared widths, codes and types of the grid mesh generator.
// ----------------------------------------------------------------------------
package gmg_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int DIM_W      = 32;
  localparam int TEX_W      = 17;
  localparam int VTX_W      = 20;
  localparam int FRAC_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = IDX_W + DIM_W;
  localparam int CELL_W     = IDX_W + CNT_W + 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIM_W / DIV_STEP;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd3;

  localparam logic [DIM_W-1:0] GRID_DIM_RESET  = 32'h0001_0000;
  localparam logic [CNT_W-1:0] GRID_CNT_RESET  = 11'd2;

  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_CELL   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] depth;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [VTX_W-1:0] tl;
    logic [VTX_W-1:0] bl;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/gmg_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_in_if
// Request channel: valid/ready handshake with command, row and column.
// ----------------------------------------------------------------------------
interface gmg_in_if import gmg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;

  modport source (output valid, output cmd, output row, output col, input ready);
  modport sink   (input valid, input cmd, input row, input col, output ready);
endinterface
`default_nettype wire

// ----- rtl/gmg_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_out_if
// Result channel: valid/ready handshake with vertex or triangle payload.
// ----------------------------------------------------------------------------
interface gmg_out_if import gmg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [DIM_W-1:0] pos_x;
  logic signed [DIM_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [VTX_W-1:0]        corner_a;
  logic [VTX_W-1:0]        corner_b;
  logic [VTX_W-1:0]        corner_c;
  logic                    last;

  modport source (
    output valid, output kind, output pos_x, output pos_z, output tex_u,
    output tex_v, output corner_a, output corner_b, output corner_c,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input pos_x, input pos_z, input tex_u,
    input tex_v, input corner_a, input corner_b, input corner_c,
    input last, output ready
  );
endinterface
`default_nettype wire

// ----- rtl/gmg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_front
// First stage: range check, dividend products and cell corner indices.
// ----------------------------------------------------------------------------
module gmg_front import gmg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic              cmd,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  col,
  output side_t             side,
  output logic [PROD_W-1:0] prod_x,
  output logic [PROD_W-1:0] prod_z,
  output logic [PROD_W-1:0] prod_u,
  output logic [PROD_W-1:0] prod_v
);

  logic              counts_ok;
  logic              vertex_bad;
  logic              cell_bad;
  logic [CNT_W-1:0]  row_e;
  logic [CNT_W-1:0]  col_e;
  logic [CNT_W-1:0]  row_p1;
  logic [CELL_W-1:0] tl_full;
  logic [CELL_W-1:0] bl_full;
  side_t             side_next;

  assign row_e  = CNT_W'(row);
  assign col_e  = CNT_W'(col);
  assign row_p1 = row_e + CNT_W'(1);

  assign counts_ok = (cfg.rows >= CNT_W'(2)) && (cfg.rows <= CNT_W'(MAX_SIDE))
                  && (cfg.cols >= CNT_W'(2)) && (cfg.cols <= CNT_W'(MAX_SIDE));
  assign vertex_bad = (row_e >= cfg.rows) || (col_e >= cfg.cols);
  assign cell_bad   = (row_e >= cfg.rows - CNT_W'(1)) || (col_e >= cfg.cols - CNT_W'(1));

  assign tl_full = CELL_W'(row) * CELL_W'(cfg.cols) + CELL_W'(col);
  assign bl_full = CELL_W'(row_p1) * CELL_W'(cfg.cols) + CELL_W'(col);

  always_comb begin
    side_next.valid = in_valid;
    side_next.tl    = tl_full[VTX_W-1:0];
    side_next.bl    = bl_full[VTX_W-1:0];
    if (!counts_ok) begin
      side_next.kind = KIND_ERROR;
    end else if (cmd == CMD_VERTEX) begin
      side_next.kind = vertex_bad ? KIND_ERROR : KIND_VERTEX;
    end else begin
      side_next.kind = cell_bad ? KIND_ERROR : KIND_TRI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= PROD_W'(col) * PROD_W'(cfg.width);
      prod_z <= PROD_W'(row) * PROD_W'(cfg.depth);
      prod_u <= PROD_W'({col, FRAC_W'(0)});
      prod_v <= PROD_W'({row, FRAC_W'(0)});
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gmg_div_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_div_lane
// Pipelined restoring divider, four quotient bits per stage, 10-bit divisor.
// ----------------------------------------------------------------------------
module gmg_div_lane import gmg_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] dividend,
  input  logic [IDX_W-1:0]  divisor,
  output logic [DIM_W-1:0]  quotient
);

  logic [IDX_W-1:0] rem_q  [DIV_STAGES-1];
  logic [DIM_W-1:0] work_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [IDX_W-1:0] rem_in;
    logic [IDX_W-1:0] rem_out;
    logic [DIM_W-1:0] work_in;
    logic [DIM_W-1:0] work_out;

    if (s == 0) begin : g_first
      // upper dividend bits already sit below the divisor for in-range requests
      assign rem_in  = dividend[PROD_W-1:DIM_W];
      assign work_in = dividend[DIM_W-1:0];
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
    end

    always_comb begin
      logic [IDX_W:0] trial;
      rem_out  = rem_in;
      work_out = work_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        trial    = {rem_out, work_out[DIM_W-1]};
        work_out = {work_out[DIM_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_out     = IDX_W'(trial - {1'b0, divisor});
          work_out[0] = 1'b1;
        end else begin
          rem_out = trial[IDX_W-1:0];
        end
      end
    end

    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= rem_out;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        work_q[s] <= work_out;
      end
    end
  end

  assign quotient = work_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/gmg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gmg_back
// Last stage: centering, saturation, field clearing and triangle beats.
// ----------------------------------------------------------------------------
module gmg_back import gmg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  side_t            side,
  input  logic [DIM_W-1:0] quot_x,
  input  logic [DIM_W-1:0] quot_z,
  input  logic [DIM_W-1:0] quot_u,
  input  logic [DIM_W-1:0] quot_v,
  output logic             en,
  gmg_out_if.source        rsp
);

  logic                    full;
  logic                    beat;
  kind_t                   kind;
  logic [DIM_W-1:0]        pos_x;
  logic [DIM_W-1:0]        pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [VTX_W-1:0]        tl;
  logic [VTX_W-1:0]        tr;
  logic [VTX_W-1:0]        bl;
  logic [VTX_W-1:0]        br;

  logic signed [DIM_W:0]   x_wide;
  logic [DIM_W-1:0]        x_sat;
  logic [DIM_W-1:0]        z_val;
  logic                    is_vtx;
  logic                    is_tri;

  assign x_wide = $signed({1'b0, quot_x}) - $signed({2'b0, cfg.width[DIM_W-1:1]});
  // positive with bit 31 set is past the signed range
  assign x_sat  = (!x_wide[DIM_W] && x_wide[DIM_W-1]) ? {1'b0, {(DIM_W-1){1'b1}}}
                                                       : x_wide[DIM_W-1:0];
  assign z_val  = {1'b0, cfg.depth[DIM_W-1:1]} - quot_z;
  assign is_vtx = (side.kind == KIND_VERTEX);
  assign is_tri = (side.kind == KIND_TRI);

  assign en = !full || (rsp.ready && ((kind != KIND_TRI) || beat));

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      beat <= 1'b0;
    end else if (en) begin
      full <= side.valid;
      beat <= 1'b0;
    end else if (rsp.ready) begin
      beat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind  <= side.kind;
      pos_x <= is_vtx ? x_sat : '0;
      pos_z <= is_vtx ? z_val : '0;
      tex_u <= is_vtx ? quot_u[TEX_W-1:0] : '0;
      tex_v <= is_vtx ? quot_v[TEX_W-1:0] : '0;
      tl    <= is_tri ? side.tl : '0;
      tr    <= is_tri ? side.tl + VTX_W'(1) : '0;
      bl    <= is_tri ? side.bl : '0;
      br    <= is_tri ? side.bl + VTX_W'(1) : '0;
    end
  end

  assign rsp.valid    = full;
  assign rsp.kind     = kind;
  assign rsp.pos_x    = pos_x;
  assign rsp.pos_z    = pos_z;
  assign rsp.tex_u    = tex_u;
  assign rsp.tex_v    = tex_v;
  assign rsp.corner_a = beat ? bl : tl;
  assign rsp.corner_b = tr;
  assign rsp.corner_c = beat ? br : bl;
  assign rsp.last     = (kind != KIND_TRI) || beat;

endmodule
`default_nettype wire

// ----- rtl/grid_mesh_generator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_mesh_generator_unit
// Flat grid mesh generator: vertex positions, texture coordinates and cell
// triangles on request.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        contents
//   req      in   valid/ready      cmd, row, col
//   rsp      out  valid/ready      kind, pos_x, pos_z, tex_u, tex_v,
//                                  corner_a/b/c, last
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// one request per cycle unless the output stage holds (rsp stall, or first
// triangle of a cell); path: front stage (loads at the accepting edge), 8
// divider stages of 4 quotient bits each, output stage; a cell request
// occupies the output stage for one beat per triangle
// a stall on rsp freezes every stage; nothing is dropped or repeated
// reset clears all valid bits and loads the default grid configuration
// ----------------------------------------------------------------------------
module grid_mesh_generator_unit import gmg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  gmg_in_if.sink               req,
  gmg_out_if.source            rsp
);

  cfg_t              cfg;
  logic              en;
  side_t             front_side;
  side_t             side_q [DIV_STAGES];
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_z;
  logic [PROD_W-1:0] prod_u;
  logic [PROD_W-1:0] prod_v;
  logic [DIM_W-1:0]  quot_x;
  logic [DIM_W-1:0]  quot_z;
  logic [DIM_W-1:0]  quot_u;
  logic [DIM_W-1:0]  quot_v;
  logic [IDX_W-1:0]  cols_m1;
  logic [IDX_W-1:0]  rows_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= GRID_DIM_RESET;
      cfg.depth <= GRID_DIM_RESET;
      cfg.rows  <= GRID_CNT_RESET;
      cfg.cols  <= GRID_CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH: cfg.width <= cfg_data;
        CFG_GRID_DEPTH: cfg.depth <= cfg_data;
        CFG_ROW_COUNT:  cfg.rows  <= cfg_data[CNT_W-1:0];
        CFG_COL_COUNT:  cfg.cols  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols_m1   = IDX_W'(cfg.cols - CNT_W'(1));
  assign rows_m1   = IDX_W'(cfg.rows - CNT_W'(1));
  assign req.ready = en;

  gmg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (req.valid),
    .cmd      (req.cmd),
    .row      (req.row),
    .col      (req.col),
    .side     (front_side),
    .prod_x   (prod_x),
    .prod_z   (prod_z),
    .prod_u   (prod_u),
    .prod_v   (prod_v)
  );

  gmg_div_lane u_div_x (.clk(clk), .en(en), .dividend(prod_x), .divisor(cols_m1),
                        .quotient(quot_x));
  gmg_div_lane u_div_z (.clk(clk), .en(en), .dividend(prod_z), .divisor(rows_m1),
                        .quotient(quot_z));
  gmg_div_lane u_div_u (.clk(clk), .en(en), .dividend(prod_u), .divisor(cols_m1),
                        .quotient(quot_u));
  gmg_div_lane u_div_v (.clk(clk), .en(en), .dividend(prod_v), .divisor(rows_m1),
                        .quotient(quot_v));

  // sideband travels alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        side_q[s] <= '0;
      end
    end else if (en) begin
      side_q[0] <= front_side;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  gmg_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .side   (side_q[DIV_STAGES-1]),
    .quot_x (quot_x),
    .quot_z (quot_z),
    .quot_u (quot_u),
    .quot_v (quot_v),
    .en     (en),
    .rsp    (rsp)
  );

  a_notlast_is_tri: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.kind == KIND_TRI)
    else $error("non-final result that is not a triangle");

  a_second_tri: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && !rsp.last |=> rsp.valid && rsp.last && rsp.kind == KIND_TRI)
    else $error("second triangle of a cell missing");

  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_ERROR |->
      rsp.pos_x == '0 && rsp.pos_z == '0 && rsp.corner_a == '0 && rsp.last)
    else $error("error result carries payload");

  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while output stalled");

endmodule
`default_nettype wire

// ----- tb/grid_mesh_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// grid_mesh_generator_unit_tb
// Regression for the grid mesh generator. A directed pass covers the reset
// grid, the widest grid with x saturation, zero extents, masked count writes
// and illegal counts. Randomized phases follow: each phase programs a new
// grid, then sends vertex and cell requests; under legal counts most are in
// range, with some random and edge indices. Both handshakes idle at random.
// One long output stall backs the pipeline up into the request port. Every
// response is checked field by field against a transaction-level predictor.
// ----------------------------------------------------------------------------
module grid_mesh_generator_unit_tb;
  import gmg_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int TAIL_CYCLES   = 24;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 105;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_ITEM     = 20;
  localparam int HOLD_CYCLES   = 300;

  localparam longint unsigned ONE_Q16 = 64'd65536;
  localparam longint          X_MAX   = 64'sh0000_0000_7FFF_FFFF;

  typedef struct packed {
    kind_t             kind;
    logic [DIM_W-1:0]  pos_x;
    logic [DIM_W-1:0]  pos_z;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic [VTX_W-1:0]  corner_a;
    logic [VTX_W-1:0]  corner_b;
    logic [VTX_W-1:0]  corner_c;
    logic              last;
  } mesh_result_t;

  class mesh_scoreboard;
    mesh_result_t     pending_q[$];
    int               errors;
    logic [DIM_W-1:0] grid_w;
    logic [DIM_W-1:0] grid_d;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;

    function new();
      errors = 0;
      grid_w = GRID_DIM_RESET;
      grid_d = GRID_DIM_RESET;
      rows   = GRID_CNT_RESET;
      cols   = GRID_CNT_RESET;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH: grid_w = data;
        CFG_GRID_DEPTH: grid_d = data;
        CFG_ROW_COUNT:  rows = data[CNT_W-1:0];
        CFG_COL_COUNT:  cols = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      mesh_result_t    res;
      longint unsigned m, n, r, c, w, d, tl, bl;
      longint          sx, sz;
      res = '0;
      res.kind = KIND_ERROR;
      res.last = 1'b1;
      m = rows;
      n = cols;
      r = row;
      c = col;
      w = grid_w;
      d = grid_d;
      if (m < 2 || m > MAX_SIDE || n < 2 || n > MAX_SIDE) begin
        pending_q = {pending_q, res};
      end else if (cmd == CMD_VERTEX) begin
        if (r < m && c < n) begin
          sx = longint'((c * w) / (n - 1)) - longint'(w >> 1);
          if (sx > X_MAX) sx = X_MAX;
          sz = longint'(d >> 1) - longint'((r * d) / (m - 1));
          res.kind  = KIND_VERTEX;
          res.pos_x = sx[DIM_W-1:0];
          res.pos_z = sz[DIM_W-1:0];
          res.tex_u = TEX_W'((c * ONE_Q16) / (n - 1));
          res.tex_v = TEX_W'((r * ONE_Q16) / (m - 1));
        end
        pending_q = {pending_q, res};
      end else if (r < m - 1 && c < n - 1) begin
        tl = r * n + c;
        bl = (r + 1) * n + c;
        res.kind     = KIND_TRI;
        res.last     = 1'b0;
        res.corner_a = VTX_W'(tl);
        res.corner_b = VTX_W'(tl + 1);
        res.corner_c = VTX_W'(bl);
        pending_q = {pending_q, res};
        res.last     = 1'b1;
        res.corner_a = VTX_W'(bl);
        res.corner_b = VTX_W'(tl + 1);
        res.corner_c = VTX_W'(bl + 1);
        pending_q = {pending_q, res};
      end else begin
        pending_q = {pending_q, res};
      end
    endfunction

    task report(string what, logic [63:0] got_val, logic [63:0] exp_val);
      $display("mismatch %s: got %0h expected %0h", what, got_val, exp_val);
      errors++;
    endtask

    task check_result(mesh_result_t got);
      mesh_result_t want;
      if (pending_q.size() == 0) begin
        report("response with nothing outstanding, kind", got.kind, 0);
      end else begin
        want = pending_q.pop_front();
        if (got.kind !== want.kind) report("kind", got.kind, want.kind);
        if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
        if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
        if (got.tex_u !== want.tex_u) report("tex_u", got.tex_u, want.tex_u);
        if (got.tex_v !== want.tex_v) report("tex_v", got.tex_v, want.tex_v);
        if (got.corner_a !== want.corner_a) report("corner_a", got.corner_a, want.corner_a);
        if (got.corner_b !== want.corner_b) report("corner_b", got.corner_b, want.corner_b);
        if (got.corner_c !== want.corner_c) report("corner_c", got.corner_c, want.corner_c);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    endtask

    task check_leftover();
      if (pending_q.size() != 0) report("responses never returned", pending_q.size(), 0);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 tx_idle = 1'b0;
  logic                 rx_idle = 1'b0;
  logic                 press_go = 1'b0;
  logic                 hold_rx = 1'b0;

  mesh_scoreboard sb = new();

  gmg_in_if  req ();
  gmg_out_if rsp ();

  grid_mesh_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.cmd   <= cmd;
    req.row   <= row;
    req.col   <= col;
    do @(posedge clk); while (!req.ready);
    sb.note_request(cmd, row, col);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
  endtask

  task automatic write_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] d,
                            input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_DEPTH, d);
    write_reg(CFG_ROW_COUNT, r);
    write_reg(CFG_COL_COUNT, c);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] count_data(int unsigned cnt);
    logic [DIM_W-1:0] data;
    data = $urandom();
    data[CNT_W-1:0] = CNT_W'(cnt);
    return data;
  endfunction

  task automatic random_item(input int unsigned m, input int unsigned n);
    logic            cmd;
    logic [IDX_W-1:0] row, col;
    int unsigned     pick, rmax, cmax;
    logic            bad;
    cmd  = ($urandom_range(0, 1) == 0) ? CMD_VERTEX : CMD_CELL;
    pick = $urandom_range(0, 19);
    bad  = m < 2 || m > MAX_SIDE || n < 2 || n > MAX_SIDE;
    if (bad || pick < 3) begin
      row = IDX_W'($urandom_range(0, 1023));
      col = IDX_W'($urandom_range(0, 1023));
    end else begin
      rmax = (cmd == CMD_CELL) ? m - 2 : m - 1;
      cmax = (cmd == CMD_CELL) ? n - 2 : n - 1;
      if (pick < 5) begin
        row = IDX_W'(rmax);
        col = IDX_W'(cmax);
      end else begin
        row = IDX_W'($urandom_range(0, rmax));
        col = IDX_W'($urandom_range(0, cmax));
      end
    end
    send_item(cmd, row, col);
  endtask

  // response sink with random stalls and one long hold-off
  initial begin : rsp_sink
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      repeat (stall) begin
        rsp.ready <= 1'b0;
        @(negedge clk);
      end
      while (hold_rx) begin
        rsp.ready <= 1'b0;
        @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      @(negedge clk);
    end
  end

  initial begin : backpressure
    wait (press_go);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  always @(posedge clk) begin : rsp_monitor
    mesh_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.kind     = kind_t'(rsp.kind);
      got.pos_x    = rsp.pos_x;
      got.pos_z    = rsp.pos_z;
      got.tex_u    = rsp.tex_u;
      got.tex_v    = rsp.tex_v;
      got.corner_a = rsp.corner_a;
      got.corner_b = rsp.corner_b;
      got.corner_c = rsp.corner_c;
      got.last     = rsp.last;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("grid_mesh_generator_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [DIM_W-1:0] w, d, rd, cd;
    int unsigned      m, n;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data  = '0;
    req.valid = 1'b0;
    req.cmd   = CMD_VERTEX;
    req.row   = '0;
    req.col   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset grid: 2 x 2 vertices, unit extents
    send_item(CMD_VERTEX, 10'd0, 10'd0);
    send_item(CMD_VERTEX, 10'd0, 10'd1);
    send_item(CMD_VERTEX, 10'd1, 10'd0);
    send_item(CMD_VERTEX, 10'd1, 10'd1);
    send_item(CMD_VERTEX, 10'd2, 10'd0);
    send_item(CMD_VERTEX, 10'd0, 10'd2);
    send_item(CMD_VERTEX, 10'd1023, 10'd1023);
    send_item(CMD_CELL, 10'd0, 10'd0);
    send_item(CMD_CELL, 10'd1, 10'd0);
    send_item(CMD_CELL, 10'd0, 10'd1);

    // widest grid, odd width saturates x, column count written with junk high bits
    wait_idle();
    write_grid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1024, 32'hFFFF_F400);
    send_item(CMD_VERTEX, 10'd1023, 10'd1023);
    send_item(CMD_VERTEX, 10'd0, 10'd0);
    send_item(CMD_VERTEX, 10'd1023, 10'd0);
    send_item(CMD_VERTEX, 10'd0, 10'd1023);
    send_item(CMD_VERTEX, 10'd512, 10'd511);
    send_item(CMD_CELL, 10'd1022, 10'd1022);
    send_item(CMD_CELL, 10'd1023, 10'd0);
    send_item(CMD_CELL, 10'd0, 10'd1023);

    // zero extents
    wait_idle();
    write_grid(32'd0, 32'd0, 32'd2, 32'd1024);
    send_item(CMD_VERTEX, 10'd1, 10'd1023);
    send_item(CMD_CELL, 10'd0, 10'd1022);

    // illegal counts
    wait_idle();
    write_reg(CFG_ROW_COUNT, 32'd1);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_item(CMD_VERTEX, 10'd0, 10'd0);
    send_item(CMD_CELL, 10'd0, 10'd0);
    wait_idle();
    write_reg(CFG_ROW_COUNT, 32'd0);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_item(CMD_VERTEX, 10'd0, 10'd0);
    wait_idle();
    write_reg(CFG_ROW_COUNT, 32'd1025);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_item(CMD_VERTEX, 10'd0, 10'd0);
    wait_idle();
    write_grid(32'h0002_8000, 32'h0003_0000, 32'd2, 32'd2047);
    send_item(CMD_CELL, 10'd0, 10'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      w  = $urandom();
      d  = $urandom();
      rd = count_data($urandom_range(2, 1024));
      cd = count_data($urandom_range(2, 1024));
      case (ph)
        0: begin
          rd = count_data(2);
          cd = count_data(2);
        end
        1: begin
          w  = 32'hFFFF_FFFF;
          cd = count_data(MAX_SIDE);
        end
        2: begin
          case ($urandom_range(0, 2))
            0: rd = count_data(0);
            1: rd = count_data(1);
            default: rd = count_data($urandom_range(MAX_SIDE + 1, 2047));
          endcase
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            rd = count_data($urandom_range(2, 16));
            cd = count_data($urandom_range(2, 16));
          end
          if ($urandom_range(0, 5) == 0) w = '0;
        end
      endcase
      write_grid(w, d, rd, cd);
      m = 32'(rd[CNT_W-1:0]);
      n = 32'(cd[CNT_W-1:0]);
      tx_idle = (ph != HOLD_PHASE) && ($urandom_range(0, 3) != 0);
      rx_idle = $urandom_range(0, 3) != 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == HOLD_PHASE && i == HOLD_ITEM) press_go = 1'b1;
        random_item(m, n);
      end
    end

    wait_idle();
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("grid_mesh_generator_unit regression: pass");
    end else begin
      $display("grid_mesh_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gmg_pkg.sv
rtl/gmg_in_if.sv
rtl/gmg_out_if.sv
rtl/gmg_front.sv
rtl/gmg_div_lane.sv
rtl/gmg_back.sv
rtl/grid_mesh_generator_unit.sv
tb/grid_mesh_generator_unit_tb.sv
